// File: src/ssds_pkg.sv
// shared types, widths and constants for the seven-segment digit scanner
// depends on nothing; imported by every module of the block
package ssds_pkg;

	localparam int VALUE_W        = 14;
	localparam int DWELL_W        = 10;
	localparam int HOLD_W         = 11;
	localparam int SEL_W          = 8;
	localparam int SEG_W          = 7;
	localparam int DIGIT_W        = 4;
	localparam int IN_TDATA_W     = 24;
	localparam int OUT_TDATA_W    = 32;
	localparam int DIGIT_COUNT_DEF = 4;

	// q = (v * RECIP_10) >> RECIP_SHIFT is exact floor(v / 10) for any 14-bit v
	localparam logic [15:0] RECIP_10    = 16'd52429;
	localparam int          RECIP_SHIFT = 19;
	localparam int          PROD_W      = VALUE_W + 16;
	localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

	typedef struct packed {
		logic load;   // take a new request into the digit registers
		logic step;   // emit one digit and move to the next higher one
	} ssds_cmd_t;

	typedef struct packed {
		logic last;   // no nonzero digits remain above the current one
	} ssds_status_t;

	// elaboration-time power of ten
	function automatic int pow10(input int n);
		int r;
		r = 1;
		for (int k = 0; k < n; k++) begin
			r = r * 10;
		end
		return r;
	endfunction

	// common-cathode segments a..g in bits 0..6
	function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h67;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// File: src/ssds_ctrl.sv
// controller state machine for the digit scanner
// depends on ssds_pkg; drives the datapath through ssds_cmd_t
module ssds_ctrl
	import ssds_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	output ssds_cmd_t    cmd,
	input  ssds_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign cmd.step = (state_q == ST_RUN) && out_free;
	// a new request may enter in the cycle the final digit leaves
	assign s_tready = (state_q == ST_IDLE) || (cmd.step && status.last);
	assign cmd.load = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.step && status.last && !cmd.load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/ssds_datapath.sv
// digit extraction datapath: reciprocal divide by ten, segment lookup, output register
// depends on ssds_pkg; commanded by ssds_ctrl
module ssds_datapath
	import ssds_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                   clk,
	input  ssds_cmd_t              cmd,
	output ssds_status_t           status,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int LIMIT = pow10(DIGIT_COUNT) - 1;
	localparam logic [VALUE_W-1:0] MAX_VALUE =
		(LIMIT > (2 ** VALUE_W) - 1) ? {VALUE_W{1'b1}} : VALUE_W'(LIMIT);
	localparam logic [2:0] TOP_BIT = 3'(DIGIT_COUNT - 1);

	logic [VALUE_W-1:0] value_q;
	logic [HOLD_W-1:0]  hold_q;
	logic [POS_W-1:0]   pos_q;

	logic [SEL_W-1:0]   sel_q;
	logic [SEG_W-1:0]   seg_q;
	logic [HOLD_W-1:0]  hold_out_q;
	logic               last_q;

	logic [VALUE_W-1:0] value_in;
	logic [PROD_W-1:0]  prod;
	logic [QUOT_W-1:0]  quot;
	logic [VALUE_W-1:0] quot_x10;
	logic [DIGIT_W-1:0] digit;
	logic [2:0]         sel_bit;

	assign value_in = (s_tdata[VALUE_W-1:0] > MAX_VALUE) ? MAX_VALUE : s_tdata[VALUE_W-1:0];

	assign prod     = PROD_W'(value_q) * PROD_W'(RECIP_10);
	assign quot     = prod[PROD_W-1:RECIP_SHIFT];
	assign quot_x10 = (VALUE_W'(quot) << 3) + (VALUE_W'(quot) << 1);
	assign digit    = DIGIT_W'(value_q - quot_x10);
	assign sel_bit  = TOP_BIT - 3'(pos_q);

	assign status.last = (quot == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value_in;
			hold_q  <= HOLD_W'(s_tdata[VALUE_W +: DWELL_W]) + HOLD_W'(1);
			pos_q   <= '0;
		end else if (cmd.step) begin
			value_q <= VALUE_W'(quot);
			pos_q   <= pos_q + POS_W'(1);
		end
		if (cmd.step) begin
			sel_q      <= ~(SEL_W'(1) << sel_bit);
			seg_q      <= seg_lookup(digit);
			hold_out_q <= hold_q;
			last_q     <= status.last;
		end
	end

	assign m_tdata = {{(OUT_TDATA_W - SEL_W - SEG_W - HOLD_W){1'b0}}, hold_out_q, seg_q, sel_q};
	assign m_tlast = last_q;

endmodule

// File: src/seven_segment_digit_scan_top.sv
// top level of the seven-segment digit scanner
// depends on ssds_pkg, ssds_ctrl and ssds_datapath
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  s_      | s_tvalid/s_tready | tdata: display_value[13:0], dwell_setting[23:14]
//  m_      | m_tvalid/m_tready | tdata: digit_select[7:0], segment_pattern[14:8],
//          |                   |        hold_ms[25:15]; tlast: last_digit
//
// one digit request leaves per cycle while m_tready stays high; a value shows
// 1 to DIGIT_COUNT digits (4 for 9999)
// the rate is set by the single divide-by-ten stage (reciprocal multiply)
// that peels off one digit per cycle
// the next input request can be taken in the same cycle its predecessor's last digit
// is registered; the output register holds a digit while m_tready is low
// arst_n clears the state machine and the output valid; no clearing pass
module seven_segment_digit_scan_top
	import ssds_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // display_value, dwell_setting
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // digit_select, segment_pattern, hold_ms, zero pad
	output logic                   m_tlast    // last_digit
);

	// command and status between controller and datapath
	ssds_cmd_t    cmd;
	ssds_status_t status;

	// sequencing: accept, step digits, hand off to the output register
	ssds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// value, digit extraction and result payload
	ssds_datapath #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// File: src/ssds_checker.sv
// port-level checks for the seven-segment digit scanner
// depends on ssds_pkg; bound to seven_segment_digit_scan_top
module ssds_checker
	import ssds_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	// a stalled result request keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// exactly one digit enable is driven low
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tdata[SEL_W-1:0]) == SEL_W - 1)
		else $error("digit select not one-cold");

	// hold time is never zero and the pad bits stay clear
	a_hold_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:15] != '0 && m_tdata[OUT_TDATA_W-1:26] == '0)
		else $error("bad hold time or pad");

	// back-to-back requests only follow a one-digit run, whose final digit shows next
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 s_tvalid && s_tready |=> m_tvalid && m_tlast)
		else $error("request accepted inside a run");

endmodule

bind seven_segment_digit_scan_top ssds_checker u_ssds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
